// File: hw/rtl/nat_pkg.sv
`default_nettype none

package nat_pkg;

  // default table size
  localparam int unsigned TABLE_SLOTS = 8;

  // command codes
  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_REMOVE = 1'b1
  } nat_cmd_e;

  // result status codes
  typedef enum logic [2:0] {
    STS_FOUND    = 3'd0,
    STS_NEW      = 3'd1,
    STS_FULL     = 3'd2,
    STS_REMOVED  = 3'd3,
    STS_ABSENT   = 3'd4,
    STS_RESERVED = 3'd5
  } nat_status_e;

  // sequencer states
  typedef enum logic [1:0] {
    NS_IDLE,
    NS_SEARCH,
    NS_SHIFT,
    NS_DONE
  } nat_state_e;

endpackage

`default_nettype wire

// File: hw/rtl/node_address_table_top.sv
`default_nettype none
// sequence: a reserved address or an empty table goes straight from idle to done;
//   otherwise the search compares the stored slots in turn, and a remove then moves
//   each later entry down one place before the result is registered
// requests: one at a time; the sequencer returns to idle as the result is registered;
//   a stalled result holds the sequencer in its done state until the output register
//   frees
// reset: control and the occupancy count clear at once; memory contents are not
//   cleared, slots at or above the count are never read
module node_address_table_top #(
  parameter int unsigned TableSlots = nat_pkg::TABLE_SLOTS
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       command_i,
  input  wire logic [7:0] node_address_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      status_o,
  output logic [2:0]      slot_index_o
);
  import nat_pkg::*;

  localparam int unsigned IW = (TableSlots > 1) ? $clog2(TableSlots) : 1;
  localparam int unsigned CW = $clog2(TableSlots + 1);
  localparam int unsigned SW = (IW > 3) ? IW : 3;

  // slot memory, one read and one write port
  logic [7:0]    mem [TableSlots];
  logic [7:0]    rd_data_q;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  nat_state_e    state_q, state_d;
  nat_cmd_e      cmd_q, cmd_d;
  logic [7:0]    addr_q, addr_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] used_q, used_d;
  nat_status_e   res_status_q, res_status_d;
  logic [2:0]    res_slot_q, res_slot_d;
  logic          out_valid_q, out_valid_d;
  logic [2:0]    out_status_q, out_status_d;
  logic [2:0]    out_slot_q, out_slot_d;

  logic          in_fire;
  logic          out_free;
  logic          hit;
  logic          more;
  logic          room;
  logic [CW-1:0] idx_next_c;
  logic [SW-1:0] idx_w;
  logic [SW-1:0] used_w;

  // shared conditions
  assign in_fire    = in_valid_i && (state_q == NS_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign hit        = (rd_data_q == addr_q);
  assign idx_next_c = CW'(idx_q) + CW'(1);
  assign more       = idx_next_c < used_q;
  assign room       = used_q < CW'(TableSlots);
  assign idx_w      = SW'(idx_q);
  assign used_w     = SW'(used_q[IW-1:0]);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      NS_IDLE: begin
        if (in_fire) begin
          if (node_address_i == 8'd0 || used_q == '0) begin
            state_d = NS_DONE;
          end else begin
            state_d = NS_SEARCH;
          end
        end
      end
      NS_SEARCH: begin
        if (hit) begin
          if (cmd_q == CMD_REMOVE && more) begin
            state_d = NS_SHIFT;
          end else begin
            state_d = NS_DONE;
          end
        end else if (!more) begin
          state_d = NS_DONE;
        end
      end
      NS_SHIFT: begin
        if (!more) begin
          state_d = NS_DONE;
        end
      end
      NS_DONE: begin
        if (out_free) begin
          state_d = NS_IDLE;
        end
      end
      default: state_d = NS_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_d        = cmd_q;
    addr_d       = addr_q;
    idx_d        = idx_q;
    used_d       = used_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    mem_re       = 1'b0;
    mem_raddr    = IW'(idx_next_c);
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = addr_q;
    unique case (state_q)
      NS_IDLE: begin
        if (in_fire) begin
          cmd_d      = nat_cmd_e'(command_i);
          addr_d     = node_address_i;
          idx_d      = '0;
          res_slot_d = 3'd0;
          if (node_address_i == 8'd0) begin
            res_status_d = STS_RESERVED;
          end else if (used_q == '0) begin
            if (nat_cmd_e'(command_i) == CMD_LOOKUP) begin
              mem_we       = 1'b1;
              mem_waddr    = '0;
              mem_wdata    = node_address_i;
              used_d       = used_q + CW'(1);
              res_status_d = STS_NEW;
            end else begin
              res_status_d = STS_ABSENT;
            end
          end else begin
            mem_re    = 1'b1;
            mem_raddr = '0;
          end
        end
      end
      NS_SEARCH: begin
        res_slot_d = 3'd0;
        if (hit) begin
          if (cmd_q == CMD_LOOKUP) begin
            res_status_d = STS_FOUND;
            res_slot_d   = idx_w[2:0];
          end else if (more) begin
            mem_re = 1'b1;
            idx_d  = IW'(idx_next_c);
          end else begin
            used_d       = used_q - CW'(1);
            res_status_d = STS_REMOVED;
          end
        end else if (more) begin
          mem_re = 1'b1;
          idx_d  = IW'(idx_next_c);
        end else if (cmd_q == CMD_REMOVE) begin
          res_status_d = STS_ABSENT;
        end else if (room) begin
          mem_we       = 1'b1;
          mem_waddr    = used_q[IW-1:0];
          used_d       = used_q + CW'(1);
          res_status_d = STS_NEW;
          res_slot_d   = used_w[2:0];
        end else begin
          res_status_d = STS_FULL;
        end
      end
      NS_SHIFT: begin
        // move the entry just read down one place
        mem_we    = 1'b1;
        mem_waddr = idx_q - IW'(1);
        mem_wdata = rd_data_q;
        if (more) begin
          mem_re = 1'b1;
          idx_d  = IW'(idx_next_c);
        end else begin
          used_d       = used_q - CW'(1);
          res_status_d = STS_REMOVED;
          res_slot_d   = 3'd0;
        end
      end
      NS_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    if (state_q == NS_DONE && out_free) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_slot_d   = res_slot_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // slot memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= NS_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    addr_q       <= addr_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
  end

  assign in_stall_o   = (state_q != NS_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign slot_index_o = out_slot_q;

endmodule

`default_nettype wire
